// ===== hdl/ptw_pkg.sv =====
// package for the page table walker: widths, codes and helpers
package ptw_pkg;

  localparam int PAGE_SHIFT_DEF = 12;
  localparam int MAX_LEVELS_DEF = 5;

  localparam int VA_W   = 64;
  localparam int PTE_W  = 64;
  localparam int LOC_W  = 56;
  localparam int PPN_W  = 44;
  localparam int LVL_W  = 3;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 64;
  localparam int IN_DW  = 136;
  localparam int OUT_DW = 136;

  typedef enum logic [2:0] {
    RK_READ  = 3'd0,
    RK_WRITE = 3'd1,
    RK_DONE  = 3'd2,
    RK_PF    = 3'd3,
    RK_AF    = 3'd4
  } res_kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_ROOT  = 3'd1,
    REG_SUM   = 3'd2,
    REG_MXR   = 3'd3,
    REG_PBMTE = 3'd4,
    REG_ADUE  = 3'd5,
    REG_SSE   = 3'd6,
    REG_NAPOT = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] AK_FETCH = 2'd0;
  localparam logic [1:0] AK_LOAD  = 2'd1;
  localparam logic [1:0] AK_STORE = 2'd2;
  localparam logic [1:0] AK_RSVD  = 2'd3;

  localparam logic CMD_REQ = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] addr;
    logic [63:0] wval;
    logic        last;
  } res_t;

endpackage

// ===== hdl/page_table_walker.sv =====
// page table walker top level: request/response intake, pte checks, result queue
//
// usage: in_ carries either a translate request (command 0) or a pte read
// response (command 1). each accepted beat gives zero, one or two beats on
// out_. a read request beat asks the host to fetch the pte at result_address
// and return it later as a command 1 beat. a walk ends with translated,
// page fault or access fault; a missing accessed/dirty bit with hardware
// update on gives a write beat (last 0) before the translated beat.
// one input beat per cycle is taken while the output queue can hold two
// beats after this cycle's pop; a two-beat result stops intake until the
// queue can hold two beats again. a stalled receiver stops intake as soon
// as one output beat is waiting.
// the pte checks are one combinational pass.
// the cfg_ channel is always ready; registers take effect for later beats.
// reset (rst_n low, synchronous) clears the walk state, the registers and
// the output queue.
module page_table_walker import ptw_pkg::*; #(
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // command, virtual_address, access_kind, supervisor_mode, execute_check_load,
  // shadow_stack_access, cache_block_op, pte_value, pte_read_error
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // result_kind, result_address, write_value, pad
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [3:0]       mode_r;
  logic [PPN_W-1:0] root_r;
  logic sum_r, mxr_r, pbmte_r, adue_r, sse_r, napot_r;

  logic             busy_r;
  logic [LVL_W-1:0] lvl_r;
  logic [63:0]      haddr_r;
  logic [1:0]       hkind_r;
  logic [3:0]       hflags_r;
  logic [LOC_W-1:0] loc_r;

  logic             busy_nxt;
  logic [LVL_W-1:0] lvl_nxt;
  logic [63:0]      haddr_nxt;
  logic [1:0]       hkind_nxt;
  logic [3:0]       hflags_nxt;
  logic [LOC_W-1:0] loc_nxt;

  res_t q_r [2];
  logic [1:0] cnt_r;
  res_t r0, r1;
  logic [1:0] nres;

  logic        cmd;
  logic [63:0] va_in, pte;
  logic [1:0]  ak_in;
  logic        sm_in, hx_in, ss_in, cb_in, rerr;
  logic        acc;

  assign cmd   = in_tdata[0];
  assign va_in = in_tdata[64:1];
  assign ak_in = in_tdata[66:65];
  assign sm_in = in_tdata[67];
  assign hx_in = in_tdata[68];
  assign ss_in = in_tdata[69];
  assign cb_in = in_tdata[70];
  assign pte   = in_tdata[134:71];
  assign rerr  = in_tdata[135];

  assign cfg_ready = 1'b1;
  assign in_tready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign acc = in_tvalid && in_tready;

  function automatic logic [LOC_W-1:0] pte_addr(input logic [63:0] base,
                                                input logic [63:0] va,
                                                input logic [LVL_W-1:0] lvl);
    logic [8:0]  idx;
    logic [63:0] s;
    idx = 9'((va >> (PAGE_SHIFT + 9 * int'(lvl))) & 64'd511);
    s = base + {52'd0, idx, 3'd0};
    return s[LOC_W-1:0];
  endfunction

  // walk logic
  always_comb begin
    logic [1:0]  kd;
    logic [3:0]  levels;
    logic [6:0]  vabits;
    logic [63:0] top, m;
    logic [63:0] ppn;
    logic [5:0]  sh;
    logic        smode, hlvx, ssacc, cbo, fetch, load, store;
    logic        r, w, x, ssp, nbit, deny;
    logic [6:0]  nb;
    logic [63:0] ad, vpn, nm, lm, base;
    logic        pf, af, fin;
    kd = 2'd0; levels = 4'd0; vabits = 7'd0; top = '0; m = '0; ppn = '0; sh = '0;
    smode = 1'b0; hlvx = 1'b0; ssacc = 1'b0; cbo = 1'b0;
    fetch = 1'b0; load = 1'b0; store = 1'b0;
    r = 1'b0; w = 1'b0; x = 1'b0; ssp = 1'b0; nbit = 1'b0; deny = 1'b0;
    nb = '0; ad = '0; vpn = '0; nm = '0; lm = '0; base = '0;
    pf = 1'b0; af = 1'b0; fin = 1'b0;
    busy_nxt = busy_r; lvl_nxt = lvl_r; haddr_nxt = haddr_r;
    hkind_nxt = hkind_r; hflags_nxt = hflags_r; loc_nxt = loc_r;
    r0 = '0; r1 = '0; nres = 2'd0;
    if (acc) begin
      if (cmd == CMD_REQ) begin
        kd = (ak_in == AK_RSVD) ? AK_LOAD : ak_in;
        if (ss_in) kd = AK_STORE;
        busy_nxt = 1'b0;
        haddr_nxt = va_in;
        hkind_nxt = kd;
        hflags_nxt = {cb_in, ss_in, hx_in, sm_in};
        if (mode_r >= 4'd8 && mode_r <= 4'd10) levels = mode_r - 4'd5;
        if (int'(levels) > MAX_LEVELS) levels = 4'd0;
        nres = 2'd1;
        r0.last = 1'b1;
        if (levels == 4'd0) begin
          if (ss_in) begin
            r0.kind = RK_AF; r0.addr = va_in;
          end else begin
            r0.kind = RK_DONE;
            r0.addr = va_in & ~((64'd1 << PAGE_SHIFT) - 64'd1);
          end
        end else begin
          vabits = 7'(PAGE_SHIFT) + 7'd9 * {3'd0, levels};
          top = va_in >> (vabits - 7'd1);
          m = ~64'd0 >> (vabits - 7'd1);
          if (top != 64'd0 && top != m) begin
            r0.kind = RK_PF; r0.addr = va_in;
          end else begin
            busy_nxt = 1'b1;
            lvl_nxt = 3'(levels - 4'd1);
            loc_nxt = pte_addr({20'd0, root_r} << PAGE_SHIFT, va_in, 3'(levels - 4'd1));
            r0.kind = RK_READ; r0.addr = {8'd0, loc_nxt};
          end
        end
      end else if (busy_r) begin
        ppn = {20'd0, pte[53:10]};
        sh = 6'd9 * {3'd0, lvl_r};
        smode = hflags_r[0]; hlvx = hflags_r[1]; ssacc = hflags_r[2]; cbo = hflags_r[3];
        fetch = hkind_r == AK_FETCH; load = hkind_r == AK_LOAD; store = hkind_r == AK_STORE;
        r = pte[1]; w = pte[2]; x = pte[3];
        ssp = !r && w && !x;
        nbit = pte[63];
        nb = 7'd0;
        if (nbit) begin
          nb = 7'd45;
          for (int i = 43; i >= 0; i--) if (ppn[i]) nb = 7'(i + 1);
        end
        lm = (64'd1 << sh) - 64'd1;
        if (rerr) begin
          af = 1'b1;
        end else if (pte[60:54] != 7'd0) pf = 1'b1;
        else if (!napot_r && nbit) pf = 1'b1;
        else if (!pbmte_r && pte[62:61] != 2'd0) pf = 1'b1;
        else if (pte[62:61] == 2'd3) pf = 1'b1;
        else if (pte[3:0] == 4'b0001) begin
          if (pte[7] || pte[6] || pte[4] || nbit || pte[62:61] != 2'd0 || lvl_r == 3'd0)
            pf = 1'b1;
          else begin
            lvl_nxt = lvl_r - 3'd1;
            loc_nxt = pte_addr(ppn << PAGE_SHIFT, haddr_r, lvl_r - 3'd1);
            nres = 2'd1;
            r0.kind = RK_READ; r0.addr = {8'd0, loc_nxt}; r0.last = 1'b1;
          end
        end
        else if (pte[4] ? (smode && (fetch || !sum_r)) : !smode) pf = 1'b1;
        else if (!pte[0] || (!r && w && ((!sse_r && !x) || x))) pf = 1'b1;
        else if ((nbit && (ppn == 64'd0 || lvl_r != 3'd0)) || (nb != 7'd0 && nb != 7'd4))
          pf = 1'b1;
        else if ((ppn & lm) != 64'd0) pf = 1'b1;
        else if (ssp && ((store && !ssacc) || cbo)) af = 1'b1;
        else if (ssp && fetch) af = 1'b1;
        else if (((r && w) || x) && ssacc) af = 1'b1;
        else begin
          if (fetch || hlvx) deny = !x;
          else if (load) deny = !(sse_r && ssp) && !r && !(mxr_r && x);
          else deny = !w;
          if (deny) pf = 1'b1;
          else begin
            ad = store ? 64'hC0 : 64'h40;
            vpn = haddr_r >> PAGE_SHIFT;
            nm = (nb >= 7'd64) ? ~64'd0 : ((64'd1 << nb) - 64'd1);
            base = ((ppn & ~nm) | (vpn & nm) | (vpn & lm)) << PAGE_SHIFT;
            if ((pte & ad) != ad) begin
              if (!adue_r) pf = 1'b1;
              else begin
                busy_nxt = 1'b0;
                nres = 2'd2;
                r0.kind = RK_WRITE; r0.addr = {8'd0, loc_r}; r0.wval = pte | ad;
                r1.kind = RK_DONE; r1.addr = base; r1.last = 1'b1;
              end
            end else begin
              busy_nxt = 1'b0;
              nres = 2'd1;
              r0.kind = RK_DONE; r0.addr = base; r0.last = 1'b1;
            end
          end
        end
        fin = pf || af;
        if (fin) begin
          busy_nxt = 1'b0;
          nres = 2'd1;
          r0.kind = af ? RK_AF : RK_PF; r0.addr = haddr_r; r0.last = 1'b1;
        end
      end
    end
  end

  // output queue
  logic       pop;
  logic [1:0] rem;
  assign pop = out_tvalid && out_tready;
  assign rem = cnt_r - {1'b0, pop};
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata = {5'd0, q_r[0].wval, q_r[0].addr, q_r[0].kind};
  assign out_tlast = q_r[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= rem + nres;
    end
    if (nres != 2'd0 && rem == 2'd0) begin
      q_r[0] <= r0;
      q_r[1] <= r1;
    end else begin
      if (pop) q_r[0] <= q_r[1];
      if (nres != 2'd0) q_r[1] <= r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; root_r <= '0; sum_r <= 1'b0; mxr_r <= 1'b0;
      pbmte_r <= 1'b0; adue_r <= 1'b0; sse_r <= 1'b0; napot_r <= 1'b0;
      busy_r <= 1'b0; lvl_r <= '0; haddr_r <= '0; hkind_r <= '0;
      hflags_r <= '0; loc_r <= '0;
    end else begin
      busy_r <= busy_nxt; lvl_r <= lvl_nxt; haddr_r <= haddr_nxt;
      hkind_r <= hkind_nxt; hflags_r <= hflags_nxt; loc_r <= loc_nxt;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:  mode_r  <= cfg_data[3:0];
          REG_ROOT:  root_r  <= cfg_data[PPN_W-1:0];
          REG_SUM:   sum_r   <= cfg_data[0];
          REG_MXR:   mxr_r   <= cfg_data[0];
          REG_PBMTE: pbmte_r <= cfg_data[0];
          REG_ADUE:  adue_r  <= cfg_data[0];
          REG_SSE:   sse_r   <= cfg_data[0];
          REG_NAPOT: napot_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/ptw_checker.sv =====
// port-level checks for the page table walker, bound to the top level
module ptw_checker import ptw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == RK_WRITE |-> !out_tlast)
    else $error("write beat marked last");

  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != RK_WRITE |-> out_tlast)
    else $error("non-write beat not last");

  a_wval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != RK_WRITE |-> out_tdata[130:67] == 64'd0)
    else $error("write value set on non-write beat");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
  .clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

// ===== tb/sv/page_table_walker_tb.sv =====
// self-checking testbench for the page table walker: directed and random walks checked against a predictor
`timescale 1ns / 1ps

module page_table_walker_tb import ptw_pkg::*; ();

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [63:0] PTE_V = 64'h1, PTE_R = 64'h2, PTE_W = 64'h4, PTE_X = 64'h8;
  localparam logic [63:0] PTE_U = 64'h10, PTE_A = 64'h40, PTE_D = 64'h80;
  localparam logic [63:0] PTE_N = 64'h1 << 63, MTYPE_BITS = 64'h3 << 61;
  localparam logic [63:0] RESV_BITS = 64'h7f << 54, HIGH_ATTR_BITS = 64'h3ff << 54;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  page_table_walker dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and walk state
  logic [3:0] mode_r;
  logic [43:0] root_r;
  bit sum_r, mxr_r, pbmte_r, adue_r, sse_r, napot_r;
  bit busy;
  logic [2:0] cur_lvl;
  logic [63:0] held_va;
  logic [1:0] held_ak;
  logic [3:0] held_fl;
  logic [55:0] pte_loc;

  logic [IN_DW-1:0] pending_beats[$];
  res_t expected_results[$];
  int send_idle = 0, recv_stall = 0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [63:0] lmask(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [55:0] entry_addr(logic [63:0] base, logic [63:0] va, int l);
    logic [63:0] idx;
    idx = (va >> (12 + 9 * l)) & 64'd511;
    return 56'(base + idx * 8);
  endfunction

  function automatic void push_res(res_kind_t k, logic [63:0] a, logic [63:0] wv, bit lst);
    res_t r;
    r.kind = k;
    r.addr = a;
    r.wval = wv;
    r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void add_beat(logic [IN_DW-1:0] d);
    pending_beats.insert(pending_beats.size(), d);
  endfunction

  function automatic void end_walk(res_kind_t k);
    busy = 0;
    push_res(k, held_va, 64'd0, 1'b1);
  endfunction

  function automatic void predict_walk(logic [IN_DW-1:0] d);
    logic [63:0] va, pte, ppn, vpn, nm, ad, base, top;
    logic [1:0] ak;
    int levels, lvl, sh, nb, vabits, tz;
    bit sm, hl, ssa, cb, fetch, load, store, r, w, x, ssp, deny;
    if (d[0] == CMD_REQ) begin
      va = d[64:1];
      ak = d[66:65];
      if (ak == AK_RSVD) ak = AK_LOAD;
      if (d[69]) ak = AK_STORE;
      busy = 0;
      held_va = va;
      held_ak = ak;
      held_fl = {d[70], d[69], d[68], d[67]};
      levels = (mode_r >= 8 && mode_r <= 10) ? int'(mode_r) - 5 : 0;
      if (levels > MAX_LEVELS_DEF) levels = 0;
      if (levels == 0) begin
        if (d[69]) push_res(RK_AF, va, 0, 1);
        else push_res(RK_DONE, va & ~lmask(12), 0, 1);
        return;
      end
      vabits = 12 + 9 * levels;
      top = va >> (vabits - 1);
      if (top != 0 && top != lmask(64 - (vabits - 1))) begin
        push_res(RK_PF, va, 0, 1);
        return;
      end
      busy = 1;
      cur_lvl = 3'(levels - 1);
      pte_loc = entry_addr({20'd0, root_r} << 12, va, levels - 1);
      push_res(RK_READ, {8'd0, pte_loc}, 0, 1);
      return;
    end
    if (!busy) return;
    if (d[135]) begin
      end_walk(RK_AF);
      return;
    end
    pte = d[134:71];
    va = held_va;
    lvl = cur_lvl;
    sh = 9 * lvl;
    ppn = (pte & ~HIGH_ATTR_BITS) >> 10;
    sm = held_fl[0]; hl = held_fl[1]; ssa = held_fl[2]; cb = held_fl[3];
    fetch = held_ak == AK_FETCH; load = held_ak == AK_LOAD; store = held_ak == AK_STORE;
    r = (pte & PTE_R) != 0; w = (pte & PTE_W) != 0; x = (pte & PTE_X) != 0;
    ssp = !r && w && !x;
    tz = 0;
    while (tz < 64 && ppn[tz] == 1'b0) tz++;
    nb = (pte & PTE_N) ? tz + 1 : 0;
    if (pte & RESV_BITS) begin end_walk(RK_PF); return; end
    if (!napot_r && (pte & PTE_N)) begin end_walk(RK_PF); return; end
    if (!pbmte_r && (pte & MTYPE_BITS)) begin end_walk(RK_PF); return; end
    if ((pte & MTYPE_BITS) == MTYPE_BITS) begin end_walk(RK_PF); return; end
    if ((pte & (PTE_V | PTE_R | PTE_W | PTE_X)) == PTE_V) begin
      if ((pte & (PTE_D | PTE_A | PTE_U | PTE_N | MTYPE_BITS)) != 0 || lvl == 0) begin
        end_walk(RK_PF);
        return;
      end
      cur_lvl = 3'(lvl - 1);
      pte_loc = entry_addr(ppn << 12, va, lvl - 1);
      push_res(RK_READ, {8'd0, pte_loc}, 0, 1);
      return;
    end
    if ((pte & PTE_U) ? (sm && (fetch || !sum_r)) : !sm) begin end_walk(RK_PF); return; end
    if (!(pte & PTE_V) || (!r && w && ((!sse_r && !x) || x))) begin
      end_walk(RK_PF);
      return;
    end
    if (((pte & PTE_N) && (ppn == 0 || lvl != 0)) || (nb != 0 && nb != 4)) begin
      end_walk(RK_PF);
      return;
    end
    if ((ppn & lmask(sh)) != 0) begin end_walk(RK_PF); return; end
    if (ssp && ((store && !ssa) || cb)) begin end_walk(RK_AF); return; end
    if (ssp && fetch) begin end_walk(RK_AF); return; end
    if (((r && w) || x) && ssa) begin end_walk(RK_AF); return; end
    if (fetch || hl) deny = !x;
    else if (load) deny = !(sse_r && ssp) && !r && !(mxr_r && x);
    else deny = !w;
    if (deny) begin end_walk(RK_PF); return; end
    ad = PTE_A | (store ? PTE_D : 64'd0);
    vpn = va >> 12;
    nm = lmask(nb);
    base = ((ppn & ~nm) | (vpn & nm) | (vpn & lmask(sh))) << 12;
    if ((pte & ad) != ad) begin
      if (!adue_r) begin end_walk(RK_PF); return; end
      push_res(RK_WRITE, {8'd0, pte_loc}, pte | ad, 0);
    end
    busy = 0;
    push_res(RK_DONE, base, 0, 1);
  endfunction

  function automatic logic [IN_DW-1:0] req_beat(logic [63:0] va, logic [1:0] ak,
                                                bit sm, bit hl, bit ss, bit cb);
    logic [IN_DW-1:0] d;
    d = '0;
    d[0] = CMD_REQ;
    d[64:1] = va;
    d[66:65] = ak;
    d[67] = sm; d[68] = hl; d[69] = ss; d[70] = cb;
    return d;
  endfunction

  function automatic logic [IN_DW-1:0] rsp_beat(logic [63:0] pte, bit err);
    logic [IN_DW-1:0] d;
    d = '0;
    d[0] = ~CMD_REQ;
    d[134:71] = pte;
    d[135] = err;
    return d;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int mode_levels();
    return (mode_r >= 8 && mode_r <= 10) ? int'(mode_r) - 5 : 3;
  endfunction

  function automatic logic [63:0] pick_va();
    logic [63:0] va;
    int vb;
    va = rand64();
    if ($urandom_range(9) == 0) return va;
    vb = 12 + 9 * mode_levels();
    if ($urandom_range(3) == 0) va = va & lmask(vb - 1);
    else if (va[vb - 1]) va = va | ~lmask(vb - 1);
    else va = va & lmask(vb - 1);
    return va;
  endfunction

  function automatic logic [63:0] pointer_pte();
    logic [63:0] p;
    p = (rand64() & 64'h003f_ffff_ffff_fc00) | PTE_V;
    if ($urandom_range(15) == 0) p = p ^ (64'h1 << $urandom_range(63));
    return p;
  endfunction

  function automatic logic [63:0] leaf_pte();
    logic [63:0] p, ppn;
    ppn = rand64() & lmask(44);
    if ($urandom_range(2) != 0) ppn = ppn & ~lmask(9 * $urandom_range(4));
    p = (ppn << 10) | (64'($urandom) & 64'h3fe) | PTE_V;
    if ($urandom_range(3) != 0) p = p | PTE_A | PTE_D;
    if ($urandom_range(3) == 0) p = p | PTE_U;
    if ($urandom_range(11) == 0) p = p & ~PTE_V;
    if ($urandom_range(7) == 0) begin
      p = (p & ~(64'hf << 10)) | (64'h8 << 10) | PTE_N;
    end
    if ($urandom_range(9) == 0) p = p | (64'($urandom_range(3)) << 61);
    if ($urandom_range(19) == 0) p = p | (rand64() & RESV_BITS);
    return p;
  endfunction

  // one translate request, mostly followed by a plausible chain of pte responses
  function automatic void queue_walk();
    int depth;
    add_beat(req_beat(pick_va(), 2'($urandom_range(3)),
      $urandom_range(1), $urandom_range(7) == 0, $urandom_range(7) == 0,
      $urandom_range(7) == 0));
    if ($urandom_range(15) == 0) return;
    depth = $urandom_range(mode_levels() - 1);
    for (int i = 0; i < depth; i++) add_beat(rsp_beat(pointer_pte(), 0));
    if ($urandom_range(19) == 0) add_beat(rsp_beat(rand64(), 1));
    else if ($urandom_range(19) == 0) add_beat(rsp_beat(rand64(), 0));
    else add_beat(rsp_beat(leaf_pte(), 0));
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:  mode_r = value[3:0];
      REG_ROOT:  root_r = value[43:0];
      REG_SUM:   sum_r = value[0];
      REG_MXR:   mxr_r = value[0];
      REG_PBMTE: pbmte_r = value[0];
      REG_ADUE:  adue_r = value[0];
      REG_SSE:   sse_r = value[0];
      REG_NAPOT: napot_r = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [3:0] mode, logic [63:0] root, logic [5:0] flags);
    cfg_write(REG_MODE, {60'd0, mode});
    cfg_write(REG_ROOT, root);
    cfg_write(REG_SUM, {63'd0, flags[0]});
    cfg_write(REG_MXR, {63'd0, flags[1]});
    cfg_write(REG_PBMTE, {63'd0, flags[2]});
    cfg_write(REG_ADUE, {63'd0, flags[3]});
    cfg_write(REG_SSE, {63'd0, flags[4]});
    cfg_write(REG_NAPOT, {63'd0, flags[5]});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_walk(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_beats.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat kind=%0d addr=%h", out_tdata[2:0], out_tdata[66:3]);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[2:0] !== want.kind) begin
            $error("result_kind expected %0d actual %0d", want.kind, out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[66:3] !== want.addr) begin
            $error("result_address expected %h actual %h", want.addr, out_tdata[66:3]);
            errors++;
          end
          if (out_tdata[130:67] !== want.wval) begin
            $error("write_value expected %h actual %h", want.wval, out_tdata[130:67]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_tlast);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [3:0] modes[10] = '{4'd8, 4'd9, 4'd10, 4'd0, 4'd8, 4'd9, 4'd10, 4'd15, 4'd9, 4'd10};
    int idle_tab[4] = '{0, 88, 0, 21};
    int stall_tab[4] = '{0, 0, 88, 21};
    logic [63:0] root;
    logic [5:0] flags;
    mode_r = 0; root_r = 0;
    {sum_r, mxr_r, pbmte_r, adue_r, sse_r, napot_r} = '0;
    busy = 0; cur_lvl = 0; held_va = 0; held_ak = 0; held_fl = 0; pte_loc = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bare mode, reserved kind, shadow stack in bare, stray response
    add_beat(req_beat('1, AK_RSVD, 1, 0, 0, 0));
    add_beat(req_beat(64'h0, AK_FETCH, 0, 0, 0, 0));
    add_beat(req_beat(64'h1234_5678_9abc_def0, AK_STORE, 1, 0, 1, 0));
    add_beat(rsp_beat('1, 1));
    drain();
    configure(4'd8, 64'h0, 6'b001000);
    // non-canonical, read error, abandoned walk, a/d write-back, leaf at root
    add_beat(req_beat(64'h0000_0040_0000_0000, AK_LOAD, 1, 0, 0, 0));
    add_beat(req_beat('1, AK_LOAD, 1, 0, 0, 0));
    add_beat(rsp_beat(64'h0, 1));
    add_beat(req_beat(64'h0000_0000_0040_1000, AK_STORE, 1, 0, 0, 0));
    add_beat(req_beat(64'h0000_0000_0040_1000, AK_STORE, 1, 0, 0, 0));
    add_beat(rsp_beat(64'h0000_0000_0000_1001, 0));
    add_beat(rsp_beat(64'h0000_0000_0000_2001, 0));
    add_beat(rsp_beat(64'h0000_0000_0000_300f, 0));
    add_beat(req_beat(64'h0, AK_FETCH, 0, 1, 0, 1));
    add_beat(rsp_beat(64'h0000_0000_0000_00df, 0));
    add_beat(req_beat(64'h0, AK_LOAD, 1, 0, 0, 0));
    add_beat(rsp_beat(64'h3fff_ffff_ffff_fc07, 0));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin root = 64'h0; flags = 6'b000000; end
        1: begin root = 64'h0000_0fff_ffff_ffff; flags = 6'b111111; end
        default: begin root = rand64(); flags = 6'($urandom); end
      endcase
      configure(modes[ph], root, flags);
      send_idle = idle_tab[ph % 4];
      recv_stall = stall_tab[ph % 4];
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(19) == 0) add_beat(rsp_beat(rand64(), $urandom_range(1)));
        else queue_walk();
      end
      drain();
      send_idle = 0;
      recv_stall = 0;
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
